// File: sv/tls_pkg.sv
`timescale 1ns / 1ps
package tls_pkg;
	localparam int LINES_DEF    = 256;
	localparam int LINE_LEN_DEF = 128;

	localparam logic [7:0] NEWLINE = 8'd10;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_END   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
endpackage

// File: sv/tls_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
module tls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/text_line_sorter.sv
`timescale 1ns / 1ps
// Text line sorter.
//
// An item is taken at a rising edge where start is high and busy is low. The action
// port selects a write of one text byte, an end of input, or a read of the next sorted
// byte. Writes are taken without raising busy and stored straight into the line store;
// a newline or a full line closes the current line, zero bytes are dropped, and bytes
// beyond the last line slot are ignored. A write after a sort starts a new batch.
//
// End of input closes an open line, fills the order table and then runs an in-place
// quicksort with an explicit range stack. All compares go through one byte comparator
// that reads one byte of each line per step, so the sort time depends on the text.
// busy stays high for the whole sort.
//
// A read item is answered with one result, marked by strobe for exactly one cycle:
// in the cycle after acceptance when no sorted byte is available, otherwise after the
// order table, the length table and, for a text byte, the line store are read in
// turn. The receiver cannot stall results. After reset the block is loading an empty
// batch; memories need no clearing pass because nothing is read before it is written.
module text_line_sorter #(
	parameter int LINES    = tls_pkg::LINES_DEF,
	parameter int LINE_LEN = tls_pkg::LINE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       all_done
);
	import tls_pkg::*;

	localparam int LW   = $clog2(LINES);
	localparam int CW   = $clog2(LINES + 1);
	localparam int LENW = $clog2(LINE_LEN);
	localparam int SAW  = LW + LENW;

	localparam logic [CW-1:0]   LINES_C   = CW'(LINES);
	localparam logic [LENW:0]   LEN_MAX_C = (LENW + 1)'(LINE_LEN - 1);

	localparam logic [4:0] S_IDLE = 5'd0,  S_INIT = 5'd1,  S_RANGE = 5'd2, S_POPW = 5'd3,
		S_SWA = 5'd4, S_SWB = 5'd5, S_SWC = 5'd6, S_SWD = 5'd7, S_SWE = 5'd8,
		S_PI = 5'd9, S_PIW = 5'd10, S_PLW = 5'd11, S_CK = 5'd12, S_CB = 5'd13,
		S_CC = 5'd14, S_PLT = 5'd15, S_PSW = 5'd16, S_PSW2 = 5'd17, S_FA = 5'd18,
		S_FB = 5'd19, S_FC = 5'd20, S_FD = 5'd21, S_R0 = 5'd22, S_R1 = 5'd23,
		S_R2 = 5'd24, S_R3 = 5'd25;

	logic [4:0] state_q, state_d;
	logic phase_q, phase_d;  // 1 once sorted lines are ready for playback
	logic [CW-1:0] count_q, count_d;
	logic [LENW-1:0] open_q, open_d;
	logic [CW-1:0] cur_line_q, cur_line_d;
	logic [LENW-1:0] cur_pos_q, cur_pos_d;
	logic [LW-1:0] idx_q, idx_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, last_q, last_d, i_q, i_d, sp_q, sp_d;
	logic [LW-1:0] pv_q, pv_d, ci_q, ci_d, tmp_q, tmp_d;
	logic [LENW-1:0] plen_q, plen_d, la_q, la_d, k_q, k_d;
	logic [7:0] ca_q, ca_d;
	logic lt_q, lt_d;
	logic strobe_q, strobe_d, valid_q, valid_d, done_q, done_d;
	logic [7:0] obyte_q, obyte_d;

	logic st_we, ln_we, or_we, sk_we;
	logic [SAW-1:0] st_wa, st_ra;
	logic [LW-1:0] ln_wa, ln_ra, or_wa, or_ra, sk_wa, sk_ra;
	logic [7:0] st_wd, st_rd;
	logic [LENW-1:0] ln_wd, ln_rd;
	logic [LW-1:0] or_wd, or_rd;
	logic [2*CW-1:0] sk_wd, sk_rd;

	logic [CW-1:0] mid, cnt_e, lsize, rsize;
	logic [LENW-1:0] open_e, n_min;
	logic [LENW:0] open_inc;

	tls_ram #(.WIDTH(8), .DEPTH(LINES * (1 << LENW))) u_store (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
	tls_ram #(.WIDTH(LENW), .DEPTH(LINES)) u_len (
		.clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
	tls_ram #(.WIDTH(LW), .DEPTH(LINES)) u_order (
		.clk(clk), .we(or_we), .waddr(or_wa), .wdata(or_wd), .raddr(or_ra), .rdata(or_rd));
	tls_ram #(.WIDTH(2 * CW), .DEPTH(LINES)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));

	// Middle pivot of the current range and the part sizes after partitioning.
	assign mid   = lo_q + ((hi_q - lo_q - CW'(1)) >> 1);
	assign lsize = last_q - lo_q;
	assign rsize = hi_q - last_q - CW'(1);
	assign n_min = (la_q < plen_q) ? la_q : plen_q;
	// A write after playback works on a fresh, empty batch.
	assign cnt_e    = phase_q ? '0 : count_q;
	assign open_e   = phase_q ? '0 : open_q;
	assign open_inc = {1'b0, open_e} + (LENW + 1)'(1);

	always_comb begin
		state_d = state_q; phase_d = phase_q; count_d = count_q; open_d = open_q;
		cur_line_d = cur_line_q; cur_pos_d = cur_pos_q; idx_d = idx_q;
		lo_d = lo_q; hi_d = hi_q; last_d = last_q; i_d = i_q; sp_d = sp_q;
		pv_d = pv_q; ci_d = ci_q; tmp_d = tmp_q; plen_d = plen_q; la_d = la_q;
		k_d = k_q; ca_d = ca_q; lt_d = lt_q;
		strobe_d = 1'b0; valid_d = valid_q; done_d = done_q; obyte_d = obyte_q;
		st_we = 1'b0; st_wa = '0; st_wd = data_byte; st_ra = '0;
		ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
		or_we = 1'b0; or_wa = '0; or_wd = '0; or_ra = '0;
		sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_WRITE: begin
							phase_d = 1'b0;
							count_d = cnt_e;
							open_d = open_e;
							if (phase_q) begin
								cur_line_d = '0;
								cur_pos_d = '0;
							end
							if (data_byte != 8'd0 && cnt_e < LINES_C) begin
								if (data_byte == NEWLINE) begin
									ln_we = 1'b1; ln_wa = cnt_e[LW-1:0]; ln_wd = open_e;
									count_d = cnt_e + CW'(1);
									open_d = '0;
								end else begin
									st_we = 1'b1;
									st_wa = {cnt_e[LW-1:0], open_e};
									if (open_inc >= LEN_MAX_C) begin
										ln_we = 1'b1; ln_wa = cnt_e[LW-1:0];
										ln_wd = open_inc[LENW-1:0];
										count_d = cnt_e + CW'(1);
										open_d = '0;
									end else begin
										open_d = open_inc[LENW-1:0];
									end
								end
							end
						end
						ACT_END: begin
							if (!phase_q) begin
								if (open_q != '0) begin
									ln_we = 1'b1; ln_wa = count_q[LW-1:0]; ln_wd = open_q;
									count_d = count_q + CW'(1);
									open_d = '0;
								end
								i_d = '0;
								sp_d = '0;
								state_d = S_INIT;
							end
						end
						ACT_READ: begin
							if (phase_q && cur_line_q < count_q) begin
								or_ra = cur_line_q[LW-1:0];
								state_d = S_R1;
							end else begin
								strobe_d = 1'b1; obyte_d = '0; valid_d = 1'b0; done_d = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INIT: begin
				if (i_q < count_q) begin
					or_we = 1'b1; or_wa = i_q[LW-1:0]; or_wd = i_q[LW-1:0];
					i_d = i_q + CW'(1);
				end else if (count_q < CW'(2)) begin
					phase_d = 1'b1; cur_line_d = '0; cur_pos_d = '0;
					state_d = S_IDLE;
				end else begin
					lo_d = '0; hi_d = count_q;
					state_d = S_RANGE;
				end
			end
			S_RANGE: begin
				if (hi_q - lo_q >= CW'(2)) begin
					or_ra = lo_q[LW-1:0];
					state_d = S_SWB;
				end else if (sp_q != '0) begin
					sp_d = sp_q - CW'(1);
					sk_ra = sp_d[LW-1:0];
					state_d = S_POPW;
				end else begin
					phase_d = 1'b1; cur_line_d = '0; cur_pos_d = '0;
					state_d = S_IDLE;
				end
			end
			S_POPW: begin
				lo_d = sk_rd[2*CW-1:CW];
				hi_d = sk_rd[CW-1:0];
				state_d = S_RANGE;
			end
			S_SWA: begin
				or_ra = lo_q[LW-1:0];
				state_d = S_SWB;
			end
			S_SWB: begin
				tmp_d = or_rd;
				or_ra = mid[LW-1:0];
				state_d = S_SWC;
			end
			S_SWC: begin
				pv_d = or_rd;
				or_we = 1'b1; or_wa = lo_q[LW-1:0]; or_wd = or_rd;
				state_d = S_SWD;
			end
			S_SWD: begin
				or_we = 1'b1; or_wa = mid[LW-1:0]; or_wd = tmp_q;
				ln_ra = pv_q;
				last_d = lo_q;
				i_d = lo_q + CW'(1);
				state_d = S_SWE;
			end
			S_SWE: begin
				plen_d = ln_rd;
				state_d = S_PI;
			end
			S_PI: begin
				if (i_q < hi_q) begin
					or_ra = i_q[LW-1:0];
					state_d = S_PIW;
				end else begin
					state_d = S_FA;
				end
			end
			S_PIW: begin
				ci_d = or_rd;
				ln_ra = or_rd;
				state_d = S_PLW;
			end
			S_PLW: begin
				la_d = ln_rd;
				k_d = '0;
				state_d = S_CK;
			end
			// Shared byte comparator: one byte of each line per pass.
			S_CK: begin
				if (k_q == n_min) begin
					lt_d = la_q < plen_q;
					state_d = S_PLT;
				end else begin
					st_ra = {ci_q, k_q};
					state_d = S_CB;
				end
			end
			S_CB: begin
				ca_d = st_rd;
				st_ra = {pv_q, k_q};
				state_d = S_CC;
			end
			S_CC: begin
				if (ca_q != st_rd) begin
					lt_d = ca_q < st_rd;
					state_d = S_PLT;
				end else begin
					k_d = k_q + LENW'(1);
					state_d = S_CK;
				end
			end
			S_PLT: begin
				if (lt_q) begin
					last_d = last_q + CW'(1);
					or_ra = last_d[LW-1:0];
					state_d = S_PSW;
				end else begin
					i_d = i_q + CW'(1);
					state_d = S_PI;
				end
			end
			S_PSW: begin
				tmp_d = or_rd;
				or_we = 1'b1; or_wa = last_q[LW-1:0]; or_wd = ci_q;
				state_d = S_PSW2;
			end
			S_PSW2: begin
				or_we = 1'b1; or_wa = i_q[LW-1:0]; or_wd = tmp_q;
				i_d = i_q + CW'(1);
				state_d = S_PI;
			end
			S_FA: begin
				or_ra = last_q[LW-1:0];
				state_d = S_FB;
			end
			S_FB: begin
				or_we = 1'b1; or_wa = lo_q[LW-1:0]; or_wd = or_rd;
				state_d = S_FC;
			end
			S_FC: begin
				or_we = 1'b1; or_wa = last_q[LW-1:0]; or_wd = pv_q;
				state_d = S_FD;
			end
			// Push the larger part, keep working on the smaller one.
			S_FD: begin
				if (lsize < rsize) begin
					if (rsize >= CW'(2) && sp_q < LINES_C) begin
						sk_we = 1'b1; sk_wa = sp_q[LW-1:0];
						sk_wd = {last_q + CW'(1), hi_q};
						sp_d = sp_q + CW'(1);
					end
					hi_d = last_q;
				end else begin
					if (lsize >= CW'(2) && sp_q < LINES_C) begin
						sk_we = 1'b1; sk_wa = sp_q[LW-1:0];
						sk_wd = {lo_q, last_q};
						sp_d = sp_q + CW'(1);
					end
					lo_d = last_q + CW'(1);
				end
				state_d = S_RANGE;
			end
			S_R0: begin
				or_ra = cur_line_q[LW-1:0];
				state_d = S_R1;
			end
			S_R1: begin
				idx_d = or_rd;
				ln_ra = or_rd;
				state_d = S_R2;
			end
			S_R2: begin
				if (cur_pos_q < ln_rd) begin
					st_ra = {idx_q, cur_pos_q};
					state_d = S_R3;
				end else begin
					strobe_d = 1'b1; obyte_d = NEWLINE; valid_d = 1'b1;
					done_d = (cur_line_q + CW'(1) == count_q);
					cur_line_d = cur_line_q + CW'(1);
					cur_pos_d = '0;
					state_d = S_IDLE;
				end
			end
			S_R3: begin
				strobe_d = 1'b1; obyte_d = st_rd; valid_d = 1'b1; done_d = 1'b0;
				cur_pos_d = cur_pos_q + LENW'(1);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
			count_q <= '0;
			open_q <= '0;
			cur_line_q <= '0;
			cur_pos_q <= '0;
			sp_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
			open_q <= open_d;
			cur_line_q <= cur_line_d;
			cur_pos_q <= cur_pos_d;
			sp_q <= sp_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d; lo_q <= lo_d; hi_q <= hi_d; last_q <= last_d; i_q <= i_d;
		pv_q <= pv_d; ci_q <= ci_d; tmp_q <= tmp_d; plen_q <= plen_d; la_q <= la_d;
		k_q <= k_d; ca_q <= ca_d; lt_q <= lt_d;
		valid_q <= valid_d; done_q <= done_d; obyte_q <= obyte_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign out_byte  = obyte_q;
	assign out_valid = valid_q;
	assign all_done  = done_q;

	// The last line's newline is the only byte that can report completion.
	a_done_nl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && all_done |-> out_valid && out_byte == NEWLINE)
		else $error("all_done without a valid newline");
	// A result with no sorted byte carries a zero byte.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !out_valid |-> out_byte == 8'd0 && !all_done)
		else $error("invalid result carries data");
	// The block only becomes busy after accepting an item.
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");
	// The range stack never grows past its depth.
	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= LINES_C)
		else $error("range stack overflow");
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tls_pkg::*;

	localparam int LINES    = LINES_DEF;
	localparam int LINE_LEN = LINE_LEN_DEF;
	// Cycles with neither an accepted item nor a result before the run is declared hung.
	// The longest sort here is the full batch of mostly empty lines, a degenerate quicksort.
	localparam int STALL_LIMIT = 2000000;
	// Idle margin after the final drain, covering the tail of a read's answer.
	localparam int DRAIN_CYCLES = 20;
	localparam logic [1:0] ACT_NONE = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic       strobe;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       all_done;

	text_line_sorter u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .data_byte(data_byte), .strobe(strobe),
		.out_byte(out_byte), .out_valid(out_valid), .all_done(all_done)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// One expected answer to a read item.
	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       last;
	} sorted_byte_t;

	sorted_byte_t sorted_q[$];

	// Shadow copy of the sorter: the held lines, their order and the playback cursor.
	logic [7:0] line_mem [LINES][LINE_LEN];
	int         line_len [LINES];
	int         line_rank[LINES];
	int         n_lines;
	int         open_len;
	bit         playing;
	int         play_line;
	int         play_pos;

	int errors;
	int n_items;
	int n_results;
	int n_sorts;
	int idle_pct;
	int quiet_cycles;

	// Strict ordering of two held lines: bytewise unsigned, a prefix sorts first.
	function automatic int line_cmp(int a, int b);
		int n;
		n = (line_len[a] < line_len[b]) ? line_len[a] : line_len[b];
		for (int k = 0; k < n; k++) begin
			if (line_mem[a][k] != line_mem[b][k])
				return (line_mem[a][k] < line_mem[b][k]) ? -1 : 1;
		end
		if (line_len[a] == line_len[b])
			return 0;
		return (line_len[a] < line_len[b]) ? -1 : 1;
	endfunction

	function automatic void close_open_line();
		if (n_lines < LINES) begin
			line_len[n_lines] = open_len;
			n_lines++;
		end
		open_len = 0;
	endfunction

	// Lines that compare equal hold the same bytes, so the played-back text does not
	// depend on how the block's quicksort orders them. A plain insertion sort suffices.
	function automatic void sort_held_lines();
		int j;
		int t;
		for (int i = 0; i < n_lines; i++)
			line_rank[i] = i;
		for (int i = 1; i < n_lines; i++) begin
			j = i;
			while (j > 0 && line_cmp(line_rank[j], line_rank[j-1]) < 0) begin
				t = line_rank[j];
				line_rank[j] = line_rank[j-1];
				line_rank[j-1] = t;
				j--;
			end
		end
	endfunction

	// Advances the shadow state for one accepted item and queues what a read returns.
	function automatic void predict_sorter(logic [1:0] act, logic [7:0] b);
		sorted_byte_t r;
		int idx;
		case (act)
			ACT_WRITE: begin
				if (playing) begin
					// A write after the sort throws the old batch away.
					playing = 0;
					n_lines = 0;
					open_len = 0;
				end
				if (b != 8'd0 && n_lines < LINES) begin
					if (b == NEWLINE) begin
						close_open_line();
					end else begin
						line_mem[n_lines][open_len] = b;
						open_len++;
						if (open_len >= LINE_LEN - 1)
							close_open_line();
					end
				end
			end
			ACT_END: begin
				if (!playing) begin
					if (open_len > 0)
						close_open_line();
					sort_held_lines();
					play_line = 0;
					play_pos = 0;
					playing = 1;
					n_sorts++;
				end
			end
			ACT_READ: begin
				r = '0;
				if (playing && play_line < n_lines) begin
					idx = line_rank[play_line];
					r.valid = 1'b1;
					if (play_pos < line_len[idx]) begin
						r.ch = line_mem[idx][play_pos];
						play_pos++;
					end else begin
						r.ch = NEWLINE;
						r.last = (play_line + 1 == n_lines);
						play_line++;
						play_pos = 0;
					end
				end
				sorted_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Offers one item and holds it until the block takes it, then maybe idles.
	task automatic send_item(logic [1:0] act, logic [7:0] b);
		int gap;
		start     <= 1'b1;
		action    <= act;
		data_byte <= b;
		do
			@(posedge clk);
		while (busy);
		predict_sorter(act, b);
		n_items++;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender pause: nothing new goes in until every answer has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(ACT_WRITE, s[i]);
	endtask

	// Reads the whole sorted batch plus a few reads past its end.
	task automatic read_out(int extra);
		int total;
		total = 0;
		if (playing)
			for (int i = 0; i < n_lines; i++)
				total += line_len[i] + 1;
		repeat (total + extra)
			send_item(ACT_READ, 8'd0);
	endtask

	// Every result must match the oldest pending read.
	always @(posedge clk) begin
		sorted_byte_t e;
		if (arst_n && strobe) begin
			n_results++;
			if (sorted_q.size() == 0) begin
				$error("result with no read pending: out_byte=%0d", out_byte);
				errors++;
			end else begin
				e = sorted_q.pop_front();
				if (out_byte !== e.ch) begin
					$error("out_byte: expected %0d, got %0d", e.ch, out_byte);
					errors++;
				end
				if (out_valid !== e.valid) begin
					$error("out_valid: expected %0d, got %0d", e.valid, out_valid);
					errors++;
				end
				if (all_done !== e.last) begin
					$error("all_done: expected %0d, got %0d", e.last, all_done);
					errors++;
				end
			end
		end
	end

	// Hang detector: counts cycles in which nothing moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Reads before any sort, the extreme byte values, an empty line, dropped zero
	// bytes, a prefix pair, an unknown action, an end of input during playback and
	// reads beyond the last line.
	task automatic test_directed();
		send_item(ACT_READ, 8'd0);
		send_item(ACT_NONE, 8'hFF);
		write_text("ab");
		send_item(ACT_WRITE, NEWLINE);
		send_item(ACT_WRITE, 8'd255);
		send_item(ACT_WRITE, 8'd0);
		send_item(ACT_WRITE, NEWLINE);
		send_item(ACT_WRITE, NEWLINE);
		write_text("a");
		send_item(ACT_WRITE, NEWLINE);
		send_item(ACT_WRITE, 8'd1);
		send_item(ACT_END, 8'd0);
		send_item(ACT_READ, 8'd0);
		send_item(ACT_END, 8'd0);
		read_out(2);
		drain();
		// A sort of nothing: reads stay invalid and all_done never rises.
		send_item(ACT_WRITE, 8'd0);
		send_item(ACT_END, 8'd0);
		read_out(2);
		drain();
	endtask

	// A line that fills up closes by itself; the next byte opens a new line.
	task automatic test_long_line();
		for (int i = 0; i < LINE_LEN; i++)
			send_item(ACT_WRITE, 8'(i + 100));
		send_item(ACT_END, 8'd0);
		read_out(1);
		drain();
	endtask

	// Fill every line slot, mostly with empty lines, then write more; the extra bytes
	// must be ignored.
	task automatic test_line_limit();
		for (int i = 0; i < LINES; i++) begin
			if (i % 16 == 0)
				send_item(ACT_WRITE, 8'($urandom_range(65, 67)));
			send_item(ACT_WRITE, NEWLINE);
		end
		send_item(ACT_WRITE, 8'd90);
		send_item(ACT_WRITE, NEWLINE);
		send_item(ACT_END, 8'd0);
		read_out(2);
		drain();
	endtask

	// Random batches of short lines over a narrow alphabet, so that equal lines and
	// prefixes are common, with now and then any byte, a zero, noise and early aborts.
	task automatic test_random(int n_target);
		int nl;
		int ln;
		int r;
		logic [7:0] b;
		while (n_items < n_target) begin
			nl = $urandom_range(0, 6);
			for (int i = 0; i < nl; i++) begin
				ln = ($urandom_range(19) == 0) ? $urandom_range(0, LINE_LEN)
				                               : $urandom_range(0, 6);
				for (int k = 0; k < ln; k++) begin
					r = $urandom_range(99);
					if (r < 5)
						b = 8'd0;
					else if (r < 25)
						b = 8'($urandom);
					else
						b = 8'($urandom_range(97, 100));
					send_item(ACT_WRITE, b);
				end
				if ($urandom_range(4) != 0 || i + 1 < nl)
					send_item(ACT_WRITE, NEWLINE);
			end
			if ($urandom_range(9) == 0)
				send_item(ACT_NONE, 8'($urandom));
			if ($urandom_range(9) == 0)
				send_item(ACT_READ, 8'($urandom));
			send_item(ACT_END, 8'($urandom));
			if ($urandom_range(7) == 0) begin
				// Abort playback part way; the next write opens a new batch.
				repeat ($urandom_range(0, 5))
					send_item(ACT_READ, 8'd0);
			end else begin
				read_out($urandom_range(0, 2));
			end
		end
		drain();
	endtask

	initial begin
		errors       = 0;
		n_items      = 0;
		n_results    = 0;
		n_sorts      = 0;
		idle_pct     = 0;
		quiet_cycles = 0;
		n_lines      = 0;
		open_len     = 0;
		playing      = 0;
		play_line    = 0;
		play_pos     = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_WRITE;
		data_byte    = 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_long_line();
		test_line_limit();
		// The receiver cannot stall, so only the sender's idling varies by phase.
		idle_pct = 0;
		test_random(n_items + 40);
		idle_pct = 68;
		test_random(n_items + 40);
		idle_pct = 33;
		test_random(n_items + 40);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sorted_q.size() != 0) begin
			$error("%0d reads never answered", sorted_q.size());
			errors++;
		end
		$display("Covered %0d items, %0d sorted batches and %0d read answers,",
			n_items, n_sorts, n_results);
		$display("with line overflow, full lines, empty batches and sender idling.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
